/* design/tcpopt_pkg.sv */
// ----------------------------------------------------------------------------
// tcpopt_pkg
// Shared types and constants of the TCP option TLV parser: parse phases,
// stop causes, the result record and the result queue sizing.
// ----------------------------------------------------------------------------
package tcpopt_pkg;

   // option record ceiling per options area
   localparam int unsigned MAX_OPTIONS = 20;
   // largest options area in bytes
   localparam int unsigned AREA_MAX    = 40;
   // result queue depth and pointer width
   localparam int unsigned RQ_DEPTH    = 4;
   localparam int unsigned RQ_PTR_W    = $clog2(RQ_DEPTH);

   // option kinds with fixed meaning
   localparam logic [7:0] KIND_EOL = 8'd0;
   localparam logic [7:0] KIND_NOP = 8'd1;

   // csr register index
   localparam logic REG_MAX_OPTIONS = 1'b0;

   // record types
   localparam logic REC_OPTION  = 1'b0;
   localparam logic REC_SUMMARY = 1'b1;

   typedef enum logic [1:0] {
      PH_KIND = 2'd0,
      PH_LEN  = 2'd1,
      PH_SKIP = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      CAUSE_NONE   = 3'd0,
      CAUSE_EOL    = 3'd1,
      CAUSE_TRUNC  = 3'd2,
      CAUSE_BADLEN = 3'd3,
      CAUSE_LIMIT  = 3'd4
   } cause_type;

   // one result record, as queued towards the output
   typedef struct packed {
      logic       rtype;
      logic [7:0] kind;
      logic [5:0] len;
      logic [5:0] doff;
      logic [4:0] idx;
      logic [4:0] cnt;
      cause_type  cause;
      logic       last;
   } rec_type;

   // records produced by one input byte
   typedef struct packed {
      logic [1:0] num;
      rec_type    rec0;
      rec_type    rec1;
   } push_type;

endpackage

/* design/tcpopt_parser.sv */
// ----------------------------------------------------------------------------
// tcpopt_parser
// Per-byte parse state of one options area and the records each byte yields.
// ----------------------------------------------------------------------------
module tcpopt_parser import tcpopt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] byte_value,
   input  logic [5:0] area_length,
   input  logic [4:0] max_options,
   output push_type   push
);

   logic [5:0] pos_ff, pos_in;
   logic [5:0] area_ff, area_in;
   phase_type  phase_ff, phase_in;
   logic [7:0] kind_ff, kind_in;
   logic [5:0] skip_ff, skip_in;
   logic [4:0] count_ff, count_in;
   cause_type  cause_ff, cause_in;

   logic [5:0] area_eff;
   logic [6:0] pos_inc;
   logic       is_last;
   logic [4:0] limit;
   logic [5:0] start;
   logic [8:0] end_sum;
   logic       opt_valid;
   rec_type    opt_rec;
   rec_type    sum_rec;

   // area length sampled on the first byte, clamped to 1..40
   always_comb begin
      if (pos_ff == 6'd0) begin
         if (area_length > 6'(AREA_MAX)) begin
            area_eff = 6'(AREA_MAX);
         end else if (area_length == 6'd0) begin
            area_eff = 6'd1;
         end else begin
            area_eff = area_length;
         end
      end else if (area_ff == 6'd0) begin
         area_eff = 6'd1;
      end else begin
         area_eff = area_ff;
      end
   end

   assign pos_inc = {1'b0, pos_ff} + 7'd1;
   assign is_last = pos_inc >= {1'b0, area_eff};
   assign limit   = (max_options > 5'(MAX_OPTIONS)) ? 5'(MAX_OPTIONS) : max_options;
   assign start   = pos_ff - 6'd1;
   assign end_sum = {3'd0, start} + {1'b0, byte_value};

   // option parse step
   always_comb begin
      phase_in  = phase_ff;
      kind_in   = kind_ff;
      skip_in   = skip_ff;
      count_in  = count_ff;
      cause_in  = cause_ff;
      opt_valid = 1'b0;
      if (cause_ff == CAUSE_NONE) begin
         case (phase_ff)
            PH_KIND: begin
               if (count_ff >= limit) begin
                  cause_in = CAUSE_LIMIT;
               end else if (byte_value == KIND_EOL) begin
                  cause_in = CAUSE_EOL;
               end else if (byte_value == KIND_NOP) begin
                  phase_in = PH_KIND;
               end else if (is_last) begin
                  cause_in = CAUSE_TRUNC;
               end else begin
                  kind_in  = byte_value;
                  phase_in = PH_LEN;
               end
            end
            PH_LEN: begin
               if (byte_value < 8'd2 || end_sum > {3'd0, area_eff}) begin
                  cause_in = CAUSE_BADLEN;
               end else begin
                  opt_valid = 1'b1;
                  count_in  = count_ff + 5'd1;
                  skip_in   = byte_value[5:0] - 6'd2;
                  phase_in  = (byte_value[5:0] == 6'd2) ? PH_KIND : PH_SKIP;
               end
            end
            PH_SKIP: begin
               if (skip_ff > 6'd1) begin
                  skip_in = skip_ff - 6'd1;
               end else begin
                  skip_in  = 6'd0;
                  phase_in = PH_KIND;
               end
            end
            default: begin
               phase_in = PH_KIND;
            end
         endcase
      end
   end

   // position and area bookkeeping
   always_comb begin
      pos_in  = is_last ? 6'd0 : pos_inc[5:0];
      area_in = is_last ? 6'd0 : area_eff;
   end

   // result records for this byte
   always_comb begin
      opt_rec       = '0;
      opt_rec.rtype = REC_OPTION;
      opt_rec.kind  = kind_ff;
      opt_rec.len   = byte_value[5:0];
      opt_rec.doff  = pos_inc[5:0];
      opt_rec.idx   = count_ff;
      opt_rec.cause = CAUSE_NONE;
      opt_rec.last  = !is_last;

      sum_rec       = '0;
      sum_rec.rtype = REC_SUMMARY;
      sum_rec.cnt   = count_in;
      sum_rec.cause = cause_in;
      sum_rec.last  = 1'b1;

      push = '0;
      if (opt_valid && is_last) begin
         push.num  = 2'd2;
         push.rec0 = opt_rec;
         push.rec1 = sum_rec;
      end else if (opt_valid) begin
         push.num  = 2'd1;
         push.rec0 = opt_rec;
      end else if (is_last) begin
         push.num  = 2'd1;
         push.rec0 = sum_rec;
      end
      if (!step) begin
         push.num = 2'd0;
      end
   end

   // parse state, cleared after each area's summary
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         area_ff  <= '0;
         phase_ff <= PH_KIND;
         kind_ff  <= '0;
         skip_ff  <= '0;
         count_ff <= '0;
         cause_ff <= CAUSE_NONE;
      end else if (step) begin
         pos_ff <= pos_in;
         area_ff <= area_in;
         if (is_last) begin
            phase_ff <= PH_KIND;
            kind_ff  <= '0;
            skip_ff  <= '0;
            count_ff <= '0;
            cause_ff <= CAUSE_NONE;
         end else begin
            phase_ff <= phase_in;
            kind_ff  <= kind_in;
            skip_ff  <= skip_in;
            count_ff <= count_in;
            cause_ff <= cause_in;
         end
      end
   end

   // a byte closing the area leaves the parser at the start of the next
   a_area_wrap: assert property (@(posedge clock) disable iff (reset)
      step && is_last |=> pos_ff == 6'd0 && count_ff == 5'd0 && cause_ff == CAUSE_NONE)
      else $error("parser state not cleared after area end");

   // once stopped, no further option records inside the area
   a_stop_quiet: assert property (@(posedge clock) disable iff (reset)
      cause_ff != CAUSE_NONE |-> !opt_valid)
      else $error("option record after parse stop");

endmodule

/* design/tcpopt_rsp_fifo.sv */
// ----------------------------------------------------------------------------
// tcpopt_rsp_fifo
// Small result queue: takes up to two records per cycle, hands one out per
// transaction on the result channel.
// ----------------------------------------------------------------------------
module tcpopt_rsp_fifo import tcpopt_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   output logic     room,
   output logic     out_valid,
   input  logic     out_ready,
   output rec_type  out_rec
);

   rec_type               mem_ff [RQ_DEPTH];
   logic [RQ_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [RQ_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [RQ_PTR_W:0]     level_ff, level_in;
   logic [RQ_PTR_W-1:0]   wr_ptr_nx;
   logic                  pop;

   assign pop       = out_valid && out_ready;
   assign out_valid = level_ff != '0;
   assign out_rec   = mem_ff[rd_ptr_ff];
   assign room      = level_ff <= (RQ_PTR_W+1)'(RQ_DEPTH - 2);
   assign wr_ptr_nx = wr_ptr_ff + RQ_PTR_W'(1);

   // pointer and fill level update
   always_comb begin
      wr_ptr_in = wr_ptr_ff + RQ_PTR_W'(push.num);
      rd_ptr_in = pop ? rd_ptr_ff + RQ_PTR_W'(1) : rd_ptr_ff;
      level_in  = level_ff + (RQ_PTR_W+1)'(push.num) - (RQ_PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // record storage, first record then second in order
   always_ff @(posedge clock) begin
      if (push.num != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.rec0;
      end
      if (push.num == 2'd2) begin
         mem_ff[wr_ptr_nx] <= push.rec1;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.num != 2'd0 |-> room)
      else $error("result queue written without room");

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level_ff <= (RQ_PTR_W+1)'(RQ_DEPTH))
      else $error("result queue level out of range");

endmodule

/* design/tcp_option_tlv_parser_core.sv */
// ----------------------------------------------------------------------------
// tcp_option_tlv_parser_core
// TCP options area parser: one byte per transaction in, option records and
// an end-of-area summary out, record limit set over the csr port.
//
//   channel | direction | payload
//   req_    | in        | tdata: byte_value, area_length
//   rsp_    | out       | tdata: record fields, tuser: record_type, tlast
//   csr_    | in/out    | max_options at addresses 0 to 3
//
// One byte per cycle is taken; each byte is handled in the cycle it is
// accepted and its records are queued in a four-entry result queue.
// A record appears on rsp_ at the earliest the cycle after its byte. req_tready
// drops only when the queue holds three or more records, i.e. when rsp_ stalls.
// Synchronous reset clears parse state and sets max_options to 16.
// ----------------------------------------------------------------------------
module tcp_option_tlv_parser_core import tcpopt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // input bytes
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // byte_value[7:0], area_length[13:8], zero
   // result records
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // option_kind[7:0], option_length[13:8],
                                    // data_offset[19:14], option_index[24:20],
                                    // option_count[29:25], stop_cause[32:30], zero
   output logic [0:0]  rsp_tuser,   // record_type[0]
   output logic        rsp_tlast,
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [4:0] max_opt_ff;
   logic       csr_wr;
   logic       step;
   push_type   push;
   logic       room;
   rec_type    out_rec;

   // csr access
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_MAX_OPTIONS) ? {27'd0, max_opt_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_opt_ff <= 5'd16;
      end else if (csr_wr && csr_paddr[2] == REG_MAX_OPTIONS) begin
         max_opt_ff <= csr_pwdata[4:0];
      end
   end

   // input transaction
   assign req_tready = room;
   assign step       = req_tvalid && req_tready;

   tcpopt_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .byte_value  (req_tdata[7:0]),
      .area_length (req_tdata[13:8]),
      .max_options (max_opt_ff),
      .push        (push)
   );

   tcpopt_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_rec   (out_rec)
   );

   // result packing
   assign rsp_tdata = {7'd0, out_rec.cause, out_rec.cnt, out_rec.idx,
                       out_rec.doff, out_rec.len, out_rec.kind};
   assign rsp_tuser = out_rec.rtype;
   assign rsp_tlast = out_rec.last;

endmodule

/* tb/tcp_option_tlv_parser_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_option_tlv_parser_core_tb
// Drives options areas one byte per transaction, predicts the option records
// and end-of-area summaries in step with the accepted bytes, and compares
// every result transaction field by field. Directed areas cover the special
// cases, then random well-formed, broken and noisy areas run under several
// max_options settings and idle patterns on both sides.
// ----------------------------------------------------------------------------
module tcp_option_tlv_parser_core_tb;
   import tcpopt_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 4;
   localparam int TAIL_CYCLES    = 20;
   localparam int PRINT_CAP      = 40;
   localparam logic [2:0] MAX_OPT_ADDR = {REG_MAX_OPTIONS, 2'b00};

   // shapes of random options areas
   localparam int SHAPE_CLEAN  = 0;
   localparam int SHAPE_BADLEN = 1;
   localparam int SHAPE_NOISE  = 2;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;    // byte_value[7:0], area_length[13:8], zero
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;         // option_kind[7:0], option_length[13:8],
                                   // data_offset[19:14], option_index[24:20],
                                   // option_count[29:25], stop_cause[32:30], zero
   logic [0:0]  rsp_tuser;         // record_type[0]
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int src_idle_pct = 0;
   int snk_stall_pct = 0;
   int errors = 0;
   int bytes_sent = 0;
   int parsed_bytes = 0;
   int records_seen = 0;
   int summaries_seen = 0;
   int quiet_cycles = 0;
   int causes_seen[5] = '{default: 0};

   // parser state as predicted
   logic [4:0] limit_setting = 5'd16;
   logic [5:0] area_pos = '0;
   logic [5:0] area_len = '0;
   phase_type  parse_ph = PH_KIND;
   logic [7:0] pending_kind = '0;
   logic [5:0] skip_left = '0;
   logic [4:0] rec_tally = '0;
   cause_type  stop_cause = CAUSE_NONE;
   rec_type    awaited_records[$];

   tcp_option_tlv_parser_core u_top (.*);

   always #1 clock = ~clock;

   // receiver readiness
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= snk_stall_pct);
   end

   // watchdog on transactions of any channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable && csr_pready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [39:0] got,
                                  input logic [39:0] want);
      errors++;
      if (errors <= PRINT_CAP)
         $display("mismatch on %s at %0t ns: got 0x%0h, expected 0x%0h",
                  what, $time, got, want);
   endtask

   task automatic check_field(input string what, input logic [39:0] got,
                              input logic [39:0] want);
      if (got !== want)
         report_mismatch(what, got, want);
   endtask

   // result checker
   always @(posedge clock) begin : check_records
      rec_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_records.size() == 0) begin
            report_mismatch("record with none awaited", rsp_tdata, '0);
         end else begin
            want = awaited_records.pop_front();
            check_field("record_type", rsp_tuser[0], want.rtype);
            check_field("option_kind", rsp_tdata[7:0], want.kind);
            check_field("option_length", rsp_tdata[13:8], want.len);
            check_field("data_offset", rsp_tdata[19:14], want.doff);
            check_field("option_index", rsp_tdata[24:20], want.idx);
            check_field("option_count", rsp_tdata[29:25], want.cnt);
            check_field("stop_cause", rsp_tdata[32:30], want.cause);
            check_field("tdata padding", rsp_tdata[39:33], '0);
            check_field("last_of_run", rsp_tlast, want.last);
         end
         records_seen++;
         if (rsp_tuser[0] == REC_SUMMARY)
            summaries_seen++;
      end
   end

   // parse one accepted byte and queue the records it causes
   task automatic parse_option_byte(input logic [7:0] b, input logic [5:0] a,
                                    output bit counts);
      int unsigned limit_now;
      int          n;
      rec_type     made[2];
      limit_now = (limit_setting > MAX_OPTIONS) ? MAX_OPTIONS : limit_setting;
      n = 0;
      made[0] = '0;
      made[1] = '0;
      // area length is taken from the first byte only, clamped to 1..40
      if (area_pos == 0)
         area_len = (a > AREA_MAX) ? 6'(AREA_MAX) : ((a == 0) ? 6'd1 : a);
      counts = (stop_cause == CAUSE_NONE);

      if (stop_cause == CAUSE_NONE) begin
         case (parse_ph)
            PH_KIND: begin
               if (rec_tally >= limit_now) begin
                  stop_cause = CAUSE_LIMIT;
               end else if (b == KIND_EOL) begin
                  stop_cause = CAUSE_EOL;
               end else if (b == KIND_NOP) begin
                  // no-operation, skipped
               end else if (int'(area_pos) + 1 >= int'(area_len)) begin
                  stop_cause = CAUSE_TRUNC;
               end else begin
                  pending_kind = b;
                  parse_ph = PH_LEN;
               end
            end
            PH_LEN: begin
               // option started one byte back, length counts kind and length
               if (b < 2 || int'(area_pos) - 1 + int'(b) > int'(area_len)) begin
                  stop_cause = CAUSE_BADLEN;
               end else begin
                  made[n].rtype = REC_OPTION;
                  made[n].kind = pending_kind;
                  made[n].len = b[5:0];
                  made[n].doff = area_pos + 6'd1;
                  made[n].idx = rec_tally;
                  n++;
                  rec_tally++;
                  skip_left = b[5:0] - 6'd2;
                  parse_ph = (skip_left != 0) ? PH_SKIP : PH_KIND;
               end
            end
            default: begin
               if (skip_left != 0)
                  skip_left--;
               if (skip_left == 0)
                  parse_ph = PH_KIND;
            end
         endcase
      end

      // last byte of the area: summary, then back to a fresh area
      if (int'(area_pos) + 1 >= int'(area_len)) begin
         made[n].rtype = REC_SUMMARY;
         made[n].cnt = rec_tally;
         made[n].cause = stop_cause;
         n++;
         causes_seen[stop_cause]++;
         area_pos = '0;
         area_len = '0;
         parse_ph = PH_KIND;
         pending_kind = '0;
         skip_left = '0;
         rec_tally = '0;
         stop_cause = CAUSE_NONE;
      end else begin
         area_pos++;
      end

      if (n != 0)
         made[n - 1].last = 1'b1;
      for (int i = 0; i < n; i++)
         awaited_records.push_back(made[i]);
      counts = counts || (n != 0);
   endtask

   // one byte transaction, with random idling before it
   task automatic send_byte(input logic [7:0] b, input logic [5:0] a);
      bit counts;
      @(negedge clock);
      while ($urandom_range(99) < src_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {2'b00, a, b};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      parse_option_byte(b, a, counts);
      bytes_sent++;
      if (counts)
         parsed_bytes++;
   endtask

   // short area from a packed list, first byte in the lowest bits
   task automatic send_run(input logic [5:0] a, input int n, input logic [63:0] seq);
      for (int i = 0; i < n; i++)
         send_byte(seq[8*i +: 8], (i == 0) ? a : 6'($urandom_range(63)));
   endtask

   // hold the sender until every awaited record is out
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (awaited_records.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input bit wr, input logic [31:0] wdata,
                             output logic [31:0] rdata);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= MAX_OPT_ADDR;
      csr_pwdata <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic check_max_options(input logic [4:0] want);
      logic [31:0] rd;
      csr_access(1'b0, '0, rd);
      check_field("max_options read-back", rd, {27'd0, want});
   endtask

   task automatic write_max_options(input logic [4:0] value);
      logic [31:0] rd;
      settle();
      csr_access(1'b1, {27'd0, value}, rd);
      limit_setting = value;
      check_max_options(value);
   endtask

   // random area: clean option lists, broken lengths or plain noise
   task automatic send_area(input int shape);
      logic [7:0] body[$];
      logic [5:0] a_field;
      int         alen, r, olen, pick;
      bit         padding;
      padding = 1'b0;
      pick = $urandom_range(99);
      if (pick < 6)
         a_field = 6'($urandom_range(3));
      else if (pick < 14)
         a_field = 6'($urandom_range(63, 41));
      else
         a_field = 6'($urandom_range(40, 4));
      alen = (a_field > 40) ? 40 : ((a_field == 0) ? 1 : int'(a_field));

      while (body.size() < alen) begin
         r = alen - body.size();
         pick = $urandom_range(99);
         if (shape == SHAPE_NOISE) begin
            body.push_back(8'($urandom_range(255)));
         end else if (padding) begin
            body.push_back((pick < 50) ? 8'h00 : 8'($urandom_range(255)));
         end else if (shape == SHAPE_BADLEN && r >= 2 && pick < 30) begin
            // length below two or running past the area
            body.push_back(8'($urandom_range(255, 2)));
            body.push_back((pick < 10) ? 8'($urandom_range(1)) :
                           8'($urandom_range(255, r + 1)));
            padding = 1'b1;
         end else if (r == 1) begin
            if (pick < 40)
               body.push_back(KIND_NOP);
            else if (pick < 60)
               body.push_back(KIND_EOL);
            else
               body.push_back(8'($urandom_range(255, 2)));
         end else if (pick < 15) begin
            body.push_back(KIND_NOP);
         end else if (pick < 20) begin
            body.push_back(KIND_EOL);
            padding = 1'b1;
         end else begin
            pick = $urandom_range(99);
            if (pick < 50)
               olen = 2;
            else if (pick < 90)
               olen = $urandom_range((r < 10) ? r : 10, 2);
            else
               olen = r;
            body.push_back(8'($urandom_range(255, 2)));
            body.push_back(8'(olen));
            repeat (olen - 2) body.push_back(8'($urandom_range(255)));
         end
      end

      foreach (body[i])
         send_byte(body[i], (i == 0) ? a_field : 6'($urandom_range(63)));
   endtask

   // reset value of the register, clamped area lengths, plain option lists
   task automatic test_reset_and_options();
      check_max_options(5'd16);
      // zero area length taken as one byte, kind on the last byte
      send_run(6'd0, 1, 64'h80);
      // no-op, kind 255 with one data byte of zero, then end-of-list
      send_run(6'd5, 5, 64'h00_00_03_FF_01);
      // option record and summary caused by the same byte
      send_run(6'd4, 4, 64'h02_13_01_01);
   endtask

   // length byte below two, and an option running past the area
   task automatic test_bad_lengths();
      send_run(6'd2, 2, 64'h01_22);
      send_run(6'd3, 3, 64'h00_04_7E);
   endtask

   // record limit of zero stops on the first byte, limit of one on the second kind
   task automatic test_option_limit();
      write_max_options(5'd0);
      send_run(6'd2, 2, 64'h01_01);
      write_max_options(5'd1);
      send_run(6'd4, 4, 64'h02_41_02_40);
   endtask

   task automatic test_random_areas(input int src, input int snk,
                                    input logic [4:0] maxv, input int target);
      int goal, pick;
      write_max_options(maxv);
      src_idle_pct = src;
      snk_stall_pct = snk;
      goal = bytes_sent + target;
      while (bytes_sent < goal) begin
         pick = $urandom_range(99);
         send_area((pick < 70) ? SHAPE_CLEAN : ((pick < 88) ? SHAPE_BADLEN : SHAPE_NOISE));
         // now and then let every awaited record out before the next area
         if ($urandom_range(11) == 0)
            settle();
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_and_options();
      test_bad_lengths();
      test_option_limit();
      test_random_areas(0, 0, 5'd31, 125);
      test_random_areas(64, 0, 5'd2, 125);
      test_random_areas(0, 64, 5'd20, 125);
      test_random_areas(21, 21, 5'd5, 125);

      settle();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("sent %0d bytes (%0d parsed) at max_options 16, 0, 1, 31, 2, 20 and 5",
               bytes_sent, parsed_bytes);
      $display("checked %0d results, %0d summaries", records_seen, summaries_seen);
      $display("stops end/eol/trunc/badlen/limit %0d/%0d/%0d/%0d/%0d",
               causes_seen[CAUSE_NONE], causes_seen[CAUSE_EOL],
               causes_seen[CAUSE_TRUNC], causes_seen[CAUSE_BADLEN],
               causes_seen[CAUSE_LIMIT]);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches", errors);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
